// File: src/lsc_pkg.sv
// lsc_pkg: types, codes and constants of the laser scan cluster segmenter
// no dependencies
`default_nettype none

package lsc_pkg;

    localparam int COORD_BITS   = 24;
    localparam int ANGLE_BITS   = 16;
    localparam int SUM_BITS     = 36;
    localparam int CNT_BITS     = 13;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_ITERS = 16;
    localparam int MUL_W        = 34;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int SQ_W         = 50;
    localparam int DIV_STEPS    = SUM_BITS;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic [CNT_BITS-1:0]        POINT_LIMIT  = 13'd4096;
    localparam logic signed [PROD_W-1:0]   ROUND_HALF   = 68'sd536870912;

    // item kinds on tuser
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BEAM  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MIN_RANGE   = 3'd0;
    localparam logic [2:0] REG_MAX_RANGE   = 3'd1;
    localparam logic [2:0] REG_JOIN_TOL    = 3'd2;
    localparam logic [2:0] REG_MIN_POINTS  = 3'd3;
    localparam logic [2:0] REG_MAX_DIAG    = 3'd4;
    localparam logic [2:0] REG_MAX_ASPECT  = 3'd5;
    localparam logic [2:0] REG_FIRST_ANGLE = 3'd6;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_WORLD,
        ST_JOIN_DX,
        ST_JOIN_DY,
        ST_JOIN_TOL,
        ST_JOIN_CMP,
        ST_CLOSE,
        ST_BOX_SQX,
        ST_BOX_SQY,
        ST_BOX_DIAG,
        ST_BOX_ASP,
        ST_BOX_CHK,
        ST_DIV,
        ST_EMIT,
        ST_AFTER,
        ST_ADD
    } state_t;

    // arctan of 2^-i in 2^-24 turn units
    function automatic logic [22:0] atan_turn24(input logic [3:0] i);
        logic [22:0] v;
        case (i)
            4'd0:    v = 23'd2097152;
            4'd1:    v = 23'd1238021;
            4'd2:    v = 23'd654136;
            4'd3:    v = 23'd332050;
            4'd4:    v = 23'd166669;
            4'd5:    v = 23'd83416;
            4'd6:    v = 23'd41718;
            4'd7:    v = 23'd20860;
            4'd8:    v = 23'd10430;
            4'd9:    v = 23'd5215;
            4'd10:   v = 23'd2608;
            4'd11:   v = 23'd1304;
            4'd12:   v = 23'd652;
            4'd13:   v = 23'd326;
            4'd14:   v = 23'd163;
            default: v = 23'd81;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        logic signed [COORD_BITS-1:0] r;
        hi = (PROD_W'(1) <<< (COORD_BITS - 1)) - PROD_W'(1);
        lo = -(PROD_W'(1) <<< (COORD_BITS - 1));
        if (v > hi)
            r = hi[COORD_BITS-1:0];
        else if (v < lo)
            r = lo[COORD_BITS-1:0];
        else
            r = v[COORD_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/laser_scan_cluster_segmenter_top.sv
// laser_scan_cluster_segmenter_top: scan point clustering with iterative cordic,
// one shared multiplier and a serial divider; depends on lsc_pkg
//
// usage
//  s_* channel takes items: tuser is the kind (start with pose, beam, end of scan)
//  m_* channel gives one item per accepted cluster: centroid x, y and point count
//  apb port writes and reads the eight limit and angle registers at 4*index
//  one item is worked on at a time; s_tready is high only while the sequencer idles
//  start and ignored items go straight back to idle
//  rejected beam or end with no open cluster: close and after steps, then idle
//  valid beam: 16 cordic rotations + 2 multiplies + the join steps
//  closing a cluster: 6 box-test steps, then 2 x 36 divide steps when it passes
//  (one shared restoring divider, one quotient bit a cycle)
//  the result waits in an output register; the block keeps taking items, and only
//  stalls at the emit step while an earlier result is still not taken
//  reset clears pose, cluster state and output valid, loads register defaults
`default_nettype none

module laser_scan_cluster_segmenter_top
    import lsc_pkg::*;
#(
    parameter int MAX_BEAMS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: range_mm[15:0], range_valid[16], map_rejected[17],
    //          pose_x_mm[41:18], pose_y_mm[65:42], pose_heading[81:66]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,
    // s_tuser: mode[1:0]
    input  wire logic [1:0]  s_tuser,
    // m_tdata: centroid_x_mm[23:0], centroid_y_mm[47:24], cluster_points[60:48]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int BC_W = $clog2(MAX_BEAMS + 1);

    // configuration
    logic [15:0] min_range_reg, max_range_reg, tol_reg, diag_reg;
    logic [12:0] min_pts_reg;
    logic [3:0]  aspect_reg;
    logic [15:0] first_angle_reg, angle_step_reg;

    // scan and cluster state
    state_t state_reg, state_next;
    logic signed [23:0] robot_x_reg, robot_x_next, robot_y_reg, robot_y_next;
    logic [15:0] heading_reg, heading_next, beam_angle_reg, beam_angle_next;
    logic [BC_W-1:0] beam_count_reg, beam_count_next;
    logic open_reg, open_next;
    logic signed [SUM_BITS-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic signed [23:0] bminx_reg, bminx_next, bmaxx_reg, bmaxx_next;
    logic signed [23:0] bminy_reg, bminy_next, bmaxy_reg, bmaxy_next;
    logic signed [23:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;

    // work registers
    logic [15:0] range_reg, range_next;
    logic [1:0]  quad_reg, quad_next;
    logic signed [CORDIC_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [24:0] cz_reg, cz_next;
    logic [5:0]  iter_reg, iter_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0] acc_reg, acc_next;
    logic signed [23:0] wx_reg, wx_next, wy_reg, wy_next;
    logic [23:0] bdx_reg, bdx_next, bdy_reg, bdy_next;
    logic diag_fail_reg, diag_fail_next, add_pend_reg, add_pend_next;
    logic div_sel_reg, div_sel_next, neg_reg, neg_next;
    logic [SUM_BITS-1:0] dq_reg, dq_next;
    logic [12:0] rem_reg, rem_next;
    logic [23:0] qx_reg, qx_next, qy_reg, qy_next;
    logic m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;

    // input fields
    logic [1:0]  in_mode;
    logic [15:0] in_range;
    logic        in_rv, in_rej;
    logic signed [23:0] in_px, in_py;
    logic [15:0] in_hd;

    assign in_mode  = s_tuser;
    assign in_range = s_tdata[15:0];
    assign in_rv    = s_tdata[16];
    assign in_rej   = s_tdata[17];
    assign in_px    = s_tdata[41:18];
    assign in_py    = s_tdata[65:42];
    assign in_hd    = s_tdata[81:66];

    logic accept;
    assign accept = s_tvalid && s_tready;

    logic beam_full, beam_reject;
    assign beam_full   = beam_count_reg >= BC_W'(MAX_BEAMS);
    assign beam_reject = !in_rv || (in_range < min_range_reg) ||
                         (in_range > max_range_reg) || in_rej;

    // apb
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MIN_RANGE:   prdata = {16'd0, min_range_reg};
            REG_MAX_RANGE:   prdata = {16'd0, max_range_reg};
            REG_JOIN_TOL:    prdata = {16'd0, tol_reg};
            REG_MIN_POINTS:  prdata = {19'd0, min_pts_reg};
            REG_MAX_DIAG:    prdata = {16'd0, diag_reg};
            REG_MAX_ASPECT:  prdata = {28'd0, aspect_reg};
            REG_FIRST_ANGLE: prdata = {16'd0, first_angle_reg};
            REG_ANGLE_STEP:  prdata = {16'd0, angle_step_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg   <= 16'd600;
            max_range_reg   <= 16'd8000;
            tol_reg         <= 16'd450;
            min_pts_reg     <= 13'd8;
            diag_reg        <= 16'd1000;
            aspect_reg      <= 4'd3;
            first_angle_reg <= 16'd0;
            angle_step_reg  <= 16'd182;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MIN_RANGE:   min_range_reg   <= pwdata[15:0];
                REG_MAX_RANGE:   max_range_reg   <= pwdata[15:0];
                REG_JOIN_TOL:    tol_reg         <= pwdata[15:0];
                REG_MIN_POINTS:  min_pts_reg     <= pwdata[12:0];
                REG_MAX_DIAG:    diag_reg        <= pwdata[15:0];
                REG_MAX_ASPECT:  aspect_reg      <= pwdata[3:0];
                REG_FIRST_ANGLE: first_angle_reg <= pwdata[15:0];
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // cordic result turned to its quadrant
    logic signed [CORDIC_W-1:0] cos_val, sin_val;
    always_comb
    begin
        case (quad_reg)
            2'd0:    begin cos_val = cx_reg;  sin_val = cy_reg;  end
            2'd1:    begin cos_val = -cy_reg; sin_val = cx_reg;  end
            2'd2:    begin cos_val = -cx_reg; sin_val = -cy_reg; end
            default: begin cos_val = cy_reg;  sin_val = -cx_reg; end
        endcase
    end

    // gap to last point and box sides
    logic signed [24:0] jdx, jdy;
    logic [23:0] box_hi, box_lo;
    assign jdx = {wx_reg[23], wx_reg} - {prev_x_reg[23], prev_x_reg};
    assign jdy = {wy_reg[23], wy_reg} - {prev_y_reg[23], prev_y_reg};
    assign box_hi = (bdx_reg > bdy_reg) ? bdx_reg : bdy_reg;
    assign box_lo = (bdx_reg > bdy_reg) ? bdy_reg : bdx_reg;

    // shared multiplier, product registered every cycle
    logic signed [MUL_W-1:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = MUL_W'(range_reg);
                mul_b = cos_val;
            end
            ST_MUL_Y:
            begin
                mul_a = MUL_W'(range_reg);
                mul_b = sin_val;
            end
            ST_JOIN_DX:
            begin
                mul_a = MUL_W'(jdx);
                mul_b = MUL_W'(jdx);
            end
            ST_JOIN_DY:
            begin
                mul_a = MUL_W'(jdy);
                mul_b = MUL_W'(jdy);
            end
            ST_JOIN_TOL:
            begin
                mul_a = MUL_W'(tol_reg);
                mul_b = MUL_W'(tol_reg);
            end
            ST_BOX_SQX:
            begin
                mul_a = MUL_W'(bdx_reg);
                mul_b = MUL_W'(bdx_reg);
            end
            ST_BOX_SQY:
            begin
                mul_a = MUL_W'(bdy_reg);
                mul_b = MUL_W'(bdy_reg);
            end
            ST_BOX_DIAG:
            begin
                mul_a = MUL_W'(diag_reg);
                mul_b = MUL_W'(diag_reg);
            end
            ST_BOX_ASP:
            begin
                mul_a = MUL_W'(aspect_reg);
                mul_b = MUL_W'(box_lo);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // rounded offset added to the robot position
    logic signed [PROD_W-1:0] offset;
    assign offset = (prod_reg + ROUND_HALF) >>> 30;

    // cordic step
    logic signed [CORDIC_W-1:0] sh_x, sh_y;
    logic signed [24:0] atan_v;
    assign sh_x   = cy_reg >>> iter_reg[3:0];
    assign sh_y   = cx_reg >>> iter_reg[3:0];
    assign atan_v = 25'(atan_turn24(iter_reg[3:0]));

    // divider step
    logic [13:0] div_sh;
    logic        div_bit;
    logic [SUM_BITS-1:0] div_q;
    logic [SUM_BITS-1:0] div_qs;
    assign div_sh  = {rem_reg, dq_reg[SUM_BITS-1]};
    assign div_bit = div_sh >= {1'b0, count_reg};
    assign div_q   = {dq_reg[SUM_BITS-2:0], div_bit};
    assign div_qs  = neg_reg ? (~div_q + SUM_BITS'(1)) : div_q;

    logic [15:0] theta;
    assign theta = heading_reg + first_angle_reg + beam_angle_reg;

    logic box_fail;
    assign box_fail = diag_fail_reg || (count_reg < min_pts_reg) ||
                      ((box_lo == 24'd0) && (box_hi != 24'd0)) ||
                      ((box_lo != 24'd0) && (PROD_W'(box_hi) > prod_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_mode)
                        MODE_END:  state_next = ST_CLOSE;
                        MODE_BEAM:
                        begin
                            if (beam_full)
                                state_next = ST_IDLE;
                            else if (beam_reject)
                                state_next = ST_CLOSE;
                            else
                                state_next = ST_CORDIC;
                        end
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CORDIC:
            begin
                if (iter_reg == 6'(CORDIC_ITERS - 1))
                    state_next = ST_MUL_X;
            end
            ST_MUL_X:    state_next = ST_MUL_Y;
            ST_MUL_Y:    state_next = ST_WORLD;
            ST_WORLD:    state_next = open_reg ? ST_JOIN_DX : ST_ADD;
            ST_JOIN_DX:  state_next = ST_JOIN_DY;
            ST_JOIN_DY:  state_next = ST_JOIN_TOL;
            ST_JOIN_TOL: state_next = ST_JOIN_CMP;
            ST_JOIN_CMP:
            begin
                if (acc_reg <= SQ_W'(prod_reg) && count_reg < POINT_LIMIT)
                    state_next = ST_ADD;
                else
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:    state_next = open_reg ? ST_BOX_SQX : ST_AFTER;
            ST_BOX_SQX:  state_next = ST_BOX_SQY;
            ST_BOX_SQY:  state_next = ST_BOX_DIAG;
            ST_BOX_DIAG: state_next = ST_BOX_ASP;
            ST_BOX_ASP:  state_next = ST_BOX_CHK;
            ST_BOX_CHK:  state_next = box_fail ? ST_AFTER : ST_DIV;
            ST_DIV:
            begin
                if (iter_reg == 6'(DIV_STEPS - 1) && div_sel_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:     state_next = m_valid_reg ? ST_EMIT : ST_AFTER;
            ST_AFTER:    state_next = add_pend_reg ? ST_ADD : ST_IDLE;
            ST_ADD:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        robot_x_next    = robot_x_reg;
        robot_y_next    = robot_y_reg;
        heading_next    = heading_reg;
        beam_angle_next = beam_angle_reg;
        beam_count_next = beam_count_reg;
        open_next       = open_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        count_next      = count_reg;
        bminx_next      = bminx_reg;
        bmaxx_next      = bmaxx_reg;
        bminy_next      = bminy_reg;
        bmaxy_next      = bmaxy_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        range_next      = range_reg;
        quad_next       = quad_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        iter_next       = iter_reg;
        acc_next        = acc_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        bdx_next        = bdx_reg;
        bdy_next        = bdy_reg;
        diag_fail_next  = diag_fail_reg;
        add_pend_next   = add_pend_reg;
        div_sel_next    = div_sel_reg;
        neg_next        = neg_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    add_pend_next = 1'b0;
                    range_next    = in_range;
                    if (in_mode == MODE_START)
                    begin
                        open_next       = 1'b0;
                        robot_x_next    = in_px;
                        robot_y_next    = in_py;
                        heading_next    = in_hd;
                        beam_angle_next = '0;
                        beam_count_next = '0;
                    end
                    else if (in_mode == MODE_BEAM && !beam_full)
                    begin
                        beam_count_next = beam_count_reg + BC_W'(1);
                        beam_angle_next = beam_angle_reg + angle_step_reg;
                        quad_next       = theta[15:14];
                        cz_next         = {3'b000, theta[13:0], 8'd0};
                        cx_next         = CORDIC_START;
                        cy_next         = '0;
                        iter_next       = '0;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (!cz_reg[24])
                begin
                    cx_next = cx_reg - sh_x;
                    cy_next = cy_reg + sh_y;
                    cz_next = cz_reg - atan_v;
                end
                else
                begin
                    cx_next = cx_reg + sh_x;
                    cy_next = cy_reg - sh_y;
                    cz_next = cz_reg + atan_v;
                end
                iter_next = iter_reg + 6'd1;
            end
            ST_MUL_Y:
                wx_next = sat_coord(offset + PROD_W'(robot_x_reg));
            ST_WORLD:
                wy_next = sat_coord(offset + PROD_W'(robot_y_reg));
            ST_JOIN_DY:
                acc_next = SQ_W'(prod_reg);
            ST_JOIN_TOL:
                acc_next = acc_reg + SQ_W'(prod_reg);
            ST_JOIN_CMP:
            begin
                if (!(acc_reg <= SQ_W'(prod_reg) && count_reg < POINT_LIMIT))
                    add_pend_next = 1'b1;
            end
            ST_CLOSE:
            begin
                if (open_reg)
                begin
                    open_next = 1'b0;
                    bdx_next  = 24'(bmaxx_reg - bminx_reg);
                    bdy_next  = 24'(bmaxy_reg - bminy_reg);
                end
            end
            ST_BOX_SQY:
                acc_next = SQ_W'(prod_reg);
            ST_BOX_DIAG:
                acc_next = acc_reg + SQ_W'(prod_reg);
            ST_BOX_ASP:
                diag_fail_next = acc_reg > SQ_W'(prod_reg);
            ST_BOX_CHK:
            begin
                neg_next     = sum_x_reg[SUM_BITS-1];
                dq_next      = sum_x_reg[SUM_BITS-1] ? SUM_BITS'(-sum_x_reg)
                                                     : SUM_BITS'(sum_x_reg);
                rem_next     = '0;
                iter_next    = '0;
                div_sel_next = 1'b0;
            end
            ST_DIV:
            begin
                rem_next  = div_bit ? 13'(div_sh - {1'b0, count_reg}) : div_sh[12:0];
                dq_next   = div_q;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'(DIV_STEPS - 1))
                begin
                    if (!div_sel_reg)
                    begin
                        qx_next      = div_qs[23:0];
                        neg_next     = sum_y_reg[SUM_BITS-1];
                        dq_next      = sum_y_reg[SUM_BITS-1] ? SUM_BITS'(-sum_y_reg)
                                                             : SUM_BITS'(sum_y_reg);
                        rem_next     = '0;
                        iter_next    = '0;
                        div_sel_next = 1'b1;
                    end
                    else
                        qy_next = div_qs[23:0];
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, count_reg, qy_reg, qx_reg};
                end
            end
            ST_ADD:
            begin
                add_pend_next = 1'b0;
                prev_x_next   = wx_reg;
                prev_y_next   = wy_reg;
                if (!open_reg)
                begin
                    open_next  = 1'b1;
                    sum_x_next = SUM_BITS'(wx_reg);
                    sum_y_next = SUM_BITS'(wy_reg);
                    count_next = 13'd1;
                    bminx_next = wx_reg;
                    bmaxx_next = wx_reg;
                    bminy_next = wy_reg;
                    bmaxy_next = wy_reg;
                end
                else
                begin
                    sum_x_next = sum_x_reg + SUM_BITS'(wx_reg);
                    sum_y_next = sum_y_reg + SUM_BITS'(wy_reg);
                    count_next = count_reg + 13'd1;
                    if (wx_reg < bminx_reg) bminx_next = wx_reg;
                    if (wx_reg > bmaxx_reg) bmaxx_next = wx_reg;
                    if (wy_reg < bminy_reg) bminy_next = wy_reg;
                    if (wy_reg > bmaxy_reg) bmaxy_next = wy_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            robot_x_reg    <= '0;
            robot_y_reg    <= '0;
            heading_reg    <= '0;
            beam_angle_reg <= '0;
            beam_count_reg <= '0;
            open_reg       <= 1'b0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            count_reg      <= '0;
            bminx_reg      <= '0;
            bmaxx_reg      <= '0;
            bminy_reg      <= '0;
            bmaxy_reg      <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            add_pend_reg   <= 1'b0;
            div_sel_reg    <= 1'b0;
            iter_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            robot_x_reg    <= robot_x_next;
            robot_y_reg    <= robot_y_next;
            heading_reg    <= heading_next;
            beam_angle_reg <= beam_angle_next;
            beam_count_reg <= beam_count_next;
            open_reg       <= open_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            count_reg      <= count_next;
            bminx_reg      <= bminx_next;
            bmaxx_reg      <= bmaxx_next;
            bminy_reg      <= bminy_next;
            bmaxy_reg      <= bmaxy_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            add_pend_reg   <= add_pend_next;
            div_sel_reg    <= div_sel_next;
            iter_reg       <= iter_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        range_reg     <= range_next;
        quad_reg      <= quad_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        acc_reg       <= acc_next;
        wx_reg        <= wx_next;
        wy_reg        <= wy_next;
        bdx_reg       <= bdx_next;
        bdy_reg       <= bdy_next;
        diag_fail_reg <= diag_fail_next;
        neg_reg       <= neg_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        m_data_reg    <= m_data_next;
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata  = m_data_reg;
    end

endmodule

`default_nettype wire

// File: verif/tb_laser_scan_cluster_segmenter_top.sv
// tb_laser_scan_cluster_segmenter_top: self-checking testbench of the scan cluster segmenter
// drives beam and scan items on the stream input, checks emitted clusters; uses lsc_pkg
`default_nettype none

module tb_laser_scan_cluster_segmenter_top;
    import lsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  BEAM_CAP    = 4096;
    localparam int  SETTLE      = 400;
    localparam int  HOLD_CYCLES = 3000;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [12:0]        npts;
    } cluster_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    laser_scan_cluster_segmenter_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // expected clusters, oldest first
    cluster_t expected_clusters[$];
    int       error_count;
    longint   cycle_count;
    bit       hold_request;
    bit       sender_busy_mode;

    // shadow of the register file
    logic [31:0] limits[8];

    // shadow of the block state
    longint    robot_x, robot_y;
    int unsigned robot_heading, beam_angle, beam_count;
    bit        cluster_open;
    longint    sum_x, sum_y, box_min_x, box_max_x, box_min_y, box_max_y, prev_x, prev_y;
    int unsigned point_count;

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------
    function automatic longint sext16(input logic [31:0] v);
        return longint'($signed(v[15:0]));
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // cordic unit vector for a 24-bit turn fraction, q30
    task automatic rotate_unit(input int unsigned turn24, output longint c, output longint s);
        int unsigned quad;
        longint z, x, y, step_x, step_y;
        longint atan_tbl[16];
        atan_tbl = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                     10430, 5215, 2608, 1304, 652, 326, 163, 81};
        quad = (turn24 >> 22) & 3;
        z = longint'(turn24 & 32'h3FFFFF);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            step_x = y >>> i;
            step_y = x >>> i;
            if (z >= 0)
            begin
                x -= step_x;
                y += step_y;
                z -= atan_tbl[i];
            end
            else
            begin
                x += step_x;
                y -= step_y;
                z += atan_tbl[i];
            end
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // closes the open cluster, queues a centroid when the box tests pass
    task automatic close_open_cluster();
        longint dx, dy, w, h, lo, hi;
        longint diag2, diag_lim;
        cluster_t c;
        if (!cluster_open)
            return;
        cluster_open = 0;
        dx = box_max_x - box_min_x;
        dy = box_max_y - box_min_y;
        diag2 = dx * dx + dy * dy;
        diag_lim = longint'(limits[4][15:0]) * longint'(limits[4][15:0]);
        w = dx * 1000;
        if (w < 1)
            w = 1;
        h = dy * 1000;
        if (h < 1)
            h = 1;
        hi = (w > h) ? w : h;
        lo = (w > h) ? h : w;
        if (longint'(point_count) < longint'(limits[3][12:0]) || diag2 > diag_lim
            || hi > longint'(limits[5][3:0]) * lo)
            return;
        c.cx = 24'(sum_x / longint'(point_count));
        c.cy = 24'(sum_y / longint'(point_count));
        c.npts = 13'(point_count);
        expected_clusters = {expected_clusters, c};
    endtask

    task automatic grow_cluster(input longint x, input longint y);
        if (!cluster_open)
        begin
            cluster_open = 1;
            sum_x = x;
            sum_y = y;
            point_count = 1;
            box_min_x = x; box_max_x = x;
            box_min_y = y; box_max_y = y;
        end
        else
        begin
            sum_x += x;
            sum_y += y;
            point_count++;
            if (x < box_min_x) box_min_x = x;
            if (x > box_max_x) box_max_x = x;
            if (y < box_min_y) box_min_y = y;
            if (y > box_max_y) box_max_y = y;
        end
        prev_x = x;
        prev_y = y;
    endtask

    task automatic predict_segment(input logic [1:0] mode, input logic [87:0] d);
        longint r, c, s, wx, wy, dx, dy, tol2;
        int unsigned theta;
        if (mode == MODE_START)
        begin
            cluster_open = 0;
            robot_x = longint'($signed(d[41:18]));
            robot_y = longint'($signed(d[65:42]));
            robot_heading = d[81:66];
            beam_angle = 0;
            beam_count = 0;
            return;
        end
        if (mode == MODE_END)
        begin
            close_open_cluster();
            return;
        end
        if (mode == MODE_NONE || beam_count >= BEAM_CAP)
            return;
        beam_count++;
        r = longint'(d[15:0]);
        theta = int'((longint'(robot_heading) + sext16(limits[6]) + longint'(beam_angle))
                & 64'hFFFF);
        beam_angle = int'((longint'(beam_angle) + sext16(limits[7])) & 64'hFFFF);
        if (!d[16] || r < longint'(limits[0][15:0]) || r > longint'(limits[1][15:0]))
        begin
            close_open_cluster();
            return;
        end
        rotate_unit(theta << 8, c, s);
        wx = clamp_coord(robot_x + ((r * c + 64'sd536870912) >>> 30));
        wy = clamp_coord(robot_y + ((r * s + 64'sd536870912) >>> 30));
        if (d[17])
        begin
            close_open_cluster();
            return;
        end
        if (!cluster_open)
        begin
            grow_cluster(wx, wy);
            return;
        end
        dx = wx - prev_x;
        dy = wy - prev_y;
        tol2 = longint'(limits[2][15:0]) * longint'(limits[2][15:0]);
        if (dx * dx + dy * dy <= tol2 && point_count < 4096)
        begin
            grow_cluster(wx, wy);
            return;
        end
        close_open_cluster();
        grow_cluster(wx, wy);
    endtask

    // ---------------------------------------------------------------------
    // stream sender: returns at the falling edge after acceptance, valid still high;
    // the caller sends again or drops valid in the same step
    // ---------------------------------------------------------------------
    task automatic send_item(input logic [1:0] mode, input logic [87:0] d);
        int gap;
        gap = sender_busy_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        predict_segment(mode, d);
        @(negedge clk);
    endtask

    function automatic logic [87:0] pack_item(input logic [15:0] range_mm, input bit valid,
                                              input bit rejected, input logic [23:0] px,
                                              input logic [23:0] py, input logic [15:0] hd);
        return {6'd0, hd, py, px, rejected, valid, range_mm};
    endfunction

    task automatic send_start(input logic [23:0] px, input logic [23:0] py, input logic [15:0] hd);
        send_item(MODE_START, pack_item(16'($urandom), 1'($urandom), 1'($urandom),
                                        px, py, hd));
    endtask

    task automatic send_beam(input logic [15:0] range_mm, input bit valid, input bit rejected);
        send_item(MODE_BEAM, pack_item(range_mm, valid, rejected, 24'($urandom),
                                       24'($urandom), 16'($urandom)));
    endtask

    task automatic send_end();
        send_item(MODE_END, pack_item(16'($urandom), 1'($urandom), 1'($urandom),
                                      24'($urandom), 24'($urandom), 16'($urandom)));
    endtask

    // waits for every expected cluster and lets the sequencer settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_clusters.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // apb write: setup then access, block idle
    task automatic write_limit(input int idx, input logic [31:0] value);
        logic [31:0] width_mask[8];
        width_mask = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h1FFF, 32'hFFFF, 32'hF, 32'hFFFF,
                       32'hFFFF};
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limits[idx] = value & width_mask[idx];
    endtask

    task automatic write_all_limits(input logic [31:0] v0, v1, v2, v3, v4, v5, v6, v7);
        write_limit(REG_MIN_RANGE, v0);
        write_limit(REG_MAX_RANGE, v1);
        write_limit(REG_JOIN_TOL, v2);
        write_limit(REG_MIN_POINTS, v3);
        write_limit(REG_MAX_DIAG, v4);
        write_limit(REG_MAX_ASPECT, v5);
        write_limit(REG_FIRST_ANGLE, v6);
        write_limit(REG_ANGLE_STEP, v7);
    endtask

    // ---------------------------------------------------------------------
    // receiver: random hold-off per item, long hold when requested
    // ---------------------------------------------------------------------
    initial
    begin : receiver
        int wait_cycles;
        int phase_left;
        bit no_stall;
        m_tready = 1'b0;
        phase_left = 0;
        no_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                no_stall = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(5, 30);
            end
            phase_left--;
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 0;
            end
            else
            begin
                wait_cycles = no_stall ? 0 : $urandom_range(0, 9);
                if (wait_cycles > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // result checker, samples at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_clusters.size() == 0)
                report_mismatch($sformatf("unexpected cluster %h", m_tdata));
            else
            begin
                cluster_t e;
                e = expected_clusters.pop_front();
                if (m_tdata[23:0] !== e.cx)
                    report_mismatch($sformatf("centroid x %0d, want %0d",
                                              $signed(m_tdata[23:0]), e.cx));
                if (m_tdata[47:24] !== e.cy)
                    report_mismatch($sformatf("centroid y %0d, want %0d",
                                              $signed(m_tdata[47:24]), e.cy));
                if (m_tdata[60:48] !== e.npts)
                    report_mismatch($sformatf("point count %0d, want %0d",
                                              m_tdata[60:48], e.npts));
            end
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // one scan of smooth beams with occasional jumps and drop-outs
    task automatic run_scan(input int beams, input bit full_pose, input bit finish_scan);
        logic [15:0] rng;
        int pick;
        if (full_pose)
            send_start(24'($urandom), 24'($urandom), 16'($urandom));
        else
            send_start(24'($signed($urandom_range(0, 40000)) - 20000),
                       24'($signed($urandom_range(0, 40000)) - 20000),
                       16'(8192 + $urandom_range(0, 3) * 16384 - 2000 + $urandom_range(0, 4000)));
        rng = 16'($urandom_range(700, 4000));
        for (int i = 0; i < beams; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                rng = 16'($urandom_range(700, 4000));
            else if (pick < 10)
                rng = 16'($urandom);
            else
                rng = 16'(int'(rng) + $urandom_range(0, 30) - 15);
            send_beam(rng, pick != 97, pick == 96 || pick == 98);
        end
        if (finish_scan)
            send_end();
    endtask

    // defaults, field extremes, mode 3, beams and end without a start
    task automatic test_directed();
        send_beam(16'd1000, 1, 0);
        send_beam(16'd1000, 1, 0);
        send_end();
        send_item(MODE_NONE, '1);
        send_start(24'h7FFFFF, 24'h800000, 16'hFFFF);
        send_beam(16'hFFFF, 1, 0);
        send_beam(16'd0, 1, 0);
        send_beam(16'd2000, 0, 0);
        send_beam(16'd2000, 1, 1);
        send_start(24'h800000, 24'h7FFFFF, 16'h0000);
        send_beam(16'd8000, 1, 0);
        send_beam(16'd600, 1, 0);
        // a start while a cluster is open drops it
        send_start(24'd0, 24'd0, 16'd8192);
        for (int i = 0; i < 10; i++)
            send_beam(16'd1500, 1, 0);
        send_end();
        drain();
    endtask

    // extreme register settings
    task automatic test_extreme_limits();
        write_all_limits(32'd0, 32'hFFFF, 32'hFFFF, 32'd1, 32'hFFFF, 32'd15,
                         32'hFFFF8000, 32'h7FFF);
        send_start(24'd100, 24'd200, 16'd0);
        for (int i = 0; i < 6; i++)
            send_beam(16'($urandom), 1, 0);
        send_end();
        send_start(24'h7FFF00, 24'h7FFF00, 16'd8192);
        send_beam(16'hFFFF, 1, 0);
        send_end();
        drain();
        write_all_limits(32'hFFFF, 32'd0, 32'd0, 32'd4096, 32'd0, 32'd1, 32'h7FFF,
                         32'hFFFF8000);
        send_start(24'd0, 24'd0, 16'd0);
        send_beam(16'd0, 1, 0);
        send_beam(16'hFFFF, 1, 0);
        send_end();
        drain();
        write_all_limits(32'd0, 32'hFFFF, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0);
        // zero-size box: identical points with zero tolerance
        send_start(24'd5, 24'd5, 16'd0);
        send_beam(16'd0, 1, 0);
        send_beam(16'd0, 1, 0);
        send_end();
        drain();
    endtask

    // beams past the per-scan cap are ignored; the one cluster holds every point
    task automatic test_beam_cap();
        write_all_limits(32'd0, 32'hFFFF, 32'd100, 32'd1, 32'hFFFF, 32'd15, 32'd0, 32'd0);
        sender_busy_mode = 1;
        send_start(24'd300, 24'hFFFF00, 16'd4000);
        for (int i = 0; i < BEAM_CAP + 5; i++)
            send_beam(16'd2500, 1, 0);
        send_end();
        sender_busy_mode = 0;
        drain();
    endtask

    // random register phases, well-formed scans with noise in between
    task automatic test_random_scans();
        int sent;
        int phase;
        sent = 0;
        phase = 0;
        while (sent < 950)
        begin
            write_all_limits($urandom_range(0, 1000), $urandom_range(4000, 65535),
                             $urandom_range(30, 1200), $urandom_range(1, 12),
                             $urandom_range(300, 65535), $urandom_range(1, 15),
                             $urandom, 32'($signed($urandom_range(0, 800)) - 400));
            for (int k = 0; k < 5; k++)
            begin
                int beams;
                int noise;
                beams = $urandom_range(10, 60);
                if (phase == 1 && k == 2)
                    hold_request = 1;
                noise = $urandom_range(0, 9);
                if (noise == 0)
                begin
                    send_item(MODE_NONE, 88'({$urandom, $urandom, $urandom}));
                    send_beam(16'($urandom), 1'($urandom), 1'($urandom));
                    sent += 2;
                end
                else if (noise == 1)
                begin
                    send_end();
                    sent++;
                end
                run_scan(beams, noise == 2 || noise == 3, noise != 4);
                sent += beams + ((noise != 4) ? 2 : 1);
            end
            drain();
            phase++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_START;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        hold_request = 0;
        sender_busy_mode = 0;
        limits = '{32'd600, 32'd8000, 32'd450, 32'd8, 32'd1000, 32'd3, 32'd0, 32'd182};
        robot_x = 0; robot_y = 0;
        robot_heading = 0; beam_angle = 0; beam_count = 0;
        cluster_open = 0;
        sum_x = 0; sum_y = 0; point_count = 0;
        box_min_x = 0; box_max_x = 0; box_min_y = 0; box_max_y = 0;
        prev_x = 0; prev_y = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_extreme_limits();
        test_beam_cap();
        test_random_scans();

        drain();
        if (expected_clusters.size() != 0)
            report_mismatch("clusters never emitted");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
